// ----- src/kf5_pkg.sv -----
// ----------------------------------------------------------------------------
// kf5_pkg
// Shared constants, types and helpers of the 5x5 Kuwahara filter.
// ----------------------------------------------------------------------------
package kf5_pkg;

  localparam int MAX_ROW_PIXELS_DEF = 1024;
  localparam int FRAC = 8;              // fraction bits of means and distances

  localparam int MW   = 8 + FRAC;       // quadrant mean
  localparam int DW   = 9 + FRAC;       // one colour distance
  localparam int DSW  = DW + 4;         // sum of up to nine distances
  localparam int SQW  = 18 + 2 * FRAC;  // sum of three squared differences
  localparam int DIVW = 14 + FRAC;      // dividend of the shared divider

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_MDIV, ST_MWAIT, ST_DSUB, ST_DMUL, ST_DACC,
    ST_DSQ, ST_VDIV, ST_VWAIT, ST_PICK, ST_EMIT
  } kf5_state_t;

  function automatic longint unsigned isqrt_c(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    x = v;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // deviation threshold, sqrt(3) at full scale
  localparam longint unsigned DEV_LIMIT = isqrt_c(longint'(3 * 255 * 255) << (2 * FRAC));

  function automatic logic [3:0] quad_count(input logic [1:0] q);
    case (q)
      2'd0:    return 4'd9;
      2'd1:    return 4'd6;
      2'd2:    return 4'd6;
      default: return 4'd4;
    endcase
  endfunction

  function automatic logic [7:0] chan_of(input logic [23:0] pix, input logic [1:0] ch);
    case (ch)
      2'd0:    return pix[23:16];
      2'd1:    return pix[15:8];
      default: return pix[7:0];
    endcase
  endfunction

endpackage

// ----- src/kf5_div.sv -----
// ----------------------------------------------------------------------------
// kf5_div
// Division by a quadrant count (9, 6 or 4) through a reciprocal multiply,
// quotient registered in the cycle after start.
// ----------------------------------------------------------------------------
module kf5_div #(
  parameter int NW = kf5_pkg::DIVW
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [3:0]    den,
  output logic          done,
  output logic [NW-1:0] quo
);
  import kf5_pkg::*;

  // ceil(2^K/d) is exact for every NW-bit dividend when K = NW + 3
  localparam int K = NW + 3;
  localparam logic [NW+1:0] M9 = (NW+2)'(((64'd1 << K) + 64'd8) / 64'd9);
  localparam logic [NW+1:0] M6 = (NW+2)'(((64'd1 << K) + 64'd5) / 64'd6);
  localparam logic [NW+1:0] M4 = (NW+2)'((64'd1 << K) / 64'd4);

  logic [NW+1:0]   mul;
  logic [2*NW+1:0] prod;

  always_comb begin
    case (den)
      4'd9:    mul = M9;
      4'd6:    mul = M6;
      default: mul = M4;
    endcase
    prod = (2*NW+2)'(num) * (2*NW+2)'(mul);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) quo <= NW'(prod >> K);
  end

endmodule

// ----- src/kf5_sqrt.sv -----
// ----------------------------------------------------------------------------
// kf5_sqrt
// Digit-by-digit square root, two radicand bits per cycle, rounded half up.
// ----------------------------------------------------------------------------
module kf5_sqrt #(
  parameter int IW = kf5_pkg::SQW
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [IW-1:0]   x,
  output logic            done,
  output logic [IW/2-1:0] root
);
  import kf5_pkg::*;

  localparam int HW  = IW / 2;
  localparam int CNW = $clog2(HW + 1);

  logic [IW-1:0]  xs;
  logic [HW:0]    rem;
  logic [HW-1:0]  rt;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [HW+2:0]  r2;
  logic [HW+2:0]  trial;
  logic           ge;
  logic [HW:0]    rem_n;
  logic [HW-1:0]  rt_n;

  always_comb begin
    r2    = {rem, xs[IW-1:IW-2]};
    trial = (HW+3)'({rt, 2'b01});
    ge    = (r2 >= trial);
    rem_n = ge ? (HW+1)'(r2 - trial) : r2[HW:0];
    rt_n  = {rt[HW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xs   <= x;
        rem  <= '0;
        rt   <= '0;
        cnt  <= '0;
      end else if (busy) begin
        xs  <= {xs[IW-3:0], 2'b00};
        rem <= rem_n;
        rt  <= rt_n;
        cnt <= cnt + CNW'(1);
        if (cnt == CNW'(HW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          // round: remainder above root means v > (root + 0.5)^2
          root <= (rem_n > (HW+1)'(rt_n)) ? rt_n + HW'(1) : rt_n;
        end
      end
    end
  end

endmodule

// ----- src/kuwahara_filter_5x5_top.sv -----
// ----------------------------------------------------------------------------
// kuwahara_filter_5x5_top
// Streaming 5x5 Kuwahara filter on RGB pixels, rows held in one RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | s_tdata {blue,green,red}, s_tuser padding
//  m_      | out | m_tvalid / m_tready  | m_tdata {blue,green,red}, m_tlast frame end
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item that yields no pixel is accepted in the idle state. An item that yields
// a pixel goes through 25 window reads from the row RAM, 12 reciprocal divisions
// for the means, then per window pixel three channel differences and one square
// root unit run in turn, and 4 reciprocal divisions for the deviations.
// Reset is synchronous; the row RAM is not cleared. A result waiting on
// m_tready holds the block only when the next pixel is ready to be loaded.
// ----------------------------------------------------------------------------
module kuwahara_filter_5x5_top #(
  parameter int MAX_ROW_PIXELS = kf5_pkg::MAX_ROW_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,    // red[7:0], green[15:8], blue[23:16]
  input  logic        s_tuser,    // padding
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // red[7:0], green[15:8], blue[23:16]
  output logic        m_tlast,    // frame_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kf5_pkg::*;

  localparam int XW  = $clog2(MAX_ROW_PIXELS);
  localparam int CW  = $clog2(MAX_ROW_PIXELS + 1);
  localparam int LW  = CW + 2;
  localparam int AW  = XW + 3;
  localparam int SXW = CW + 2;
  localparam logic [MW:0] HALF_LSB = (MW+1)'(1) << (FRAC - 1);
  localparam logic [DW:0] BEST_INIT = (DW+1)'(DEV_LIMIT + 1);

  kf5_state_t state, state_next;

  logic [10:0]   fw;
  logic [15:0]   fh;
  logic [CW-1:0] weff;
  logic [15:0]   heff;

  logic [XW-1:0] in_col;
  logic [16:0]   in_row;
  logic [LW-1:0] lead;
  logic [XW-1:0] oc;
  logic [15:0]   orow;

  logic [23:0] row_mem [0:(1<<AW)-1];
  logic [23:0] rdata;
  logic [AW-1:0] raddr;

  logic [2:0]  cx, cy, cx_n, cy_n;
  logic [4:0]  kidx;
  logic [1:0]  ch, qi, bq;
  logic        rv;
  logic [1:0]  rq;
  logic [4:0]  ridx;
  logic [23:0] win [25];
  logic [11:0] sum [4][3];
  logic [MW-1:0] mean [4][3];
  logic [DSW-1:0] dsum [4];
  logic [MW-1:0]  a;
  logic [2*MW-1:0] prod;
  logic [SQW-1:0] sq, sq_next;
  logic [DW:0]    best;
  logic           bsel;
  logic [7:0]     res [3];

  logic accept, cfg_we, out_load, fe, div_start, sqrt_start, div_done, sqrt_done;
  logic in_frame, emit, col_wrap;
  logic [LW-1:0] lead_tgt;
  logic [1:0]  qk, mrq;
  logic [MW-1:0] mrd, cval;
  logic [DIVW-1:0] div_num, div_quo;
  logic [3:0]  div_den;
  logic [DW-1:0] sq_root, dev;
  logic [MW:0] rnd;
  logic signed [SXW-1:0] sx_raw, sx_max;
  logic signed [17:0]    sy_raw, sy_max;
  logic [XW-1:0] sx_c;
  logic [2:0]    sy_c;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fw <= 11'd640;
      fh <= 16'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  fw <= cfg_data[10:0];
        REG_HEIGHT: fh <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw == 11'd0)                       weff = CW'(1);
    else if (32'(fw) > MAX_ROW_PIXELS)     weff = CW'(MAX_ROW_PIXELS);
    else                                   weff = CW'(fw);
    heff = (fh == 16'd0) ? 16'd1 : fh;
  end

  // -------------------------------------------------------------- positions
  assign accept   = s_tvalid && s_tready;
  assign in_frame = (in_row < {1'b0, heff});
  assign lead_tgt = LW'({weff, 1'b0}) + LW'(2);
  assign emit     = (lead == lead_tgt);
  assign col_wrap = (CW'(in_col) + CW'(1) >= weff);
  assign fe       = (CW'(oc) == weff - CW'(1)) && (orow == heff - 16'd1);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      in_col <= '0;
      in_row <= '0;
      lead   <= '0;
      oc     <= '0;
      orow   <= '0;
    end else if (accept) begin
      if (!emit) lead <= lead + LW'(1);
      if (col_wrap) begin
        in_col <= '0;
        if (in_row != '1) in_row <= in_row + 17'd1;
      end else begin
        in_col <= in_col + XW'(1);
      end
    end else if (out_load) begin
      if (fe) begin
        in_col <= '0;
        in_row <= '0;
        lead   <= '0;
        oc     <= '0;
        orow   <= '0;
      end else if (CW'(oc) + CW'(1) >= weff) begin
        oc   <= '0;
        orow <= orow + 16'd1;
      end else begin
        oc <= oc + XW'(1);
      end
    end
  end

  // --------------------------------------------------------------- row RAM
  always_comb begin
    sx_raw = SXW'(oc) + SXW'(cx) - SXW'(2);
    sx_max = SXW'(weff) - SXW'(1);
    if (sx_raw < 0)           sx_c = '0;
    else if (sx_raw > sx_max) sx_c = sx_max[XW-1:0];
    else                      sx_c = sx_raw[XW-1:0];
    sy_raw = 18'(orow) + 18'(cy) - 18'sd2;
    sy_max = 18'(heff) - 18'sd1;
    if (sy_raw < 0)           sy_c = '0;
    else if (sy_raw > sy_max) sy_c = sy_max[2:0];
    else                      sy_c = sy_raw[2:0];
    raddr = {sy_c, sx_c};
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame)
      row_mem[{in_row[2:0], in_col}] <= s_tuser ? 24'd0
                                       : {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    rdata <= row_mem[raddr];
  end

  // ------------------------------------------------------------ arithmetic
  always_comb begin
    cx_n = (cx == 3'd4) ? 3'd0 : cx + 3'd1;
    cy_n = (cx == 3'd4) ? cy + 3'd1 : cy;
    qk   = {(cy > 3'd2), (cx > 3'd2)};
    mrq  = (state == ST_PICK) ? bq : qk;
    mrd  = mean[mrq][ch];
    cval = {chan_of(win[kidx], ch), FRAC'(0)};
    sq_next = sq + SQW'(prod);
    rnd  = (MW+1)'(mrd) + HALF_LSB;
    dev  = div_quo[DW-1:0];
    div_den = quad_count(qi);
    if (state == ST_MDIV)
      div_num = (DIVW'(sum[qi][ch]) << FRAC) + DIVW'(quad_count(qi) >> 1);
    else
      div_num = DIVW'(dsum[qi]) + DIVW'(quad_count(qi) >> 1);
  end

  kf5_div #(.NW(DIVW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  kf5_sqrt #(.IW(SQW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .x(sq_next),
    .done(sqrt_done), .root(sq_root)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && emit) state_next = ST_RD;
      end
      ST_RD:    if (kidx == 5'd25 && !rv) state_next = ST_MDIV;
      ST_MDIV: begin
        div_start  = 1'b1;
        state_next = ST_MWAIT;
      end
      ST_MWAIT: if (div_done) state_next = (qi == 2'd3 && ch == 2'd2) ? ST_DSUB : ST_MDIV;
      ST_DSUB:  state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_DACC;
      ST_DACC: begin
        if (ch == 2'd2) begin
          sqrt_start = 1'b1;
          state_next = ST_DSQ;
        end else begin
          state_next = ST_DSUB;
        end
      end
      ST_DSQ:   if (sqrt_done) state_next = (kidx == 5'd24) ? ST_VDIV : ST_DSUB;
      ST_VDIV: begin
        div_start  = 1'b1;
        state_next = ST_VWAIT;
      end
      ST_VWAIT: if (div_done) state_next = (qi == 2'd3) ? ST_PICK : ST_VDIV;
      ST_PICK:  if (ch == 2'd2) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cx   <= '0;
          cy   <= '0;
          kidx <= '0;
          rv   <= 1'b0;
          for (int q = 0; q < 4; q++)
            for (int c = 0; c < 3; c++) sum[q][c] <= '0;
        end
        ST_RD: begin
          if (kidx != 5'd25) begin
            rv   <= 1'b1;
            rq   <= qk;
            ridx <= kidx;
            kidx <= kidx + 5'd1;
            cx   <= cx_n;
            cy   <= cy_n;
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            win[ridx] <= rdata;
            for (int c = 0; c < 3; c++)
              sum[rq][c] <= sum[rq][c] + 12'(chan_of(rdata, 2'(c)));
          end
          qi <= '0;
          ch <= '0;
        end
        ST_MWAIT: begin
          if (div_done) begin
            mean[qi][ch] <= div_quo[MW-1:0];
            if (ch == 2'd2) begin
              ch <= '0;
              qi <= qi + 2'd1;
            end else begin
              ch <= ch + 2'd1;
            end
          end
          cx   <= '0;
          cy   <= '0;
          kidx <= '0;
          sq   <= '0;
          for (int q = 0; q < 4; q++) dsum[q] <= '0;
        end
        ST_DSUB: a <= (cval > mrd) ? cval - mrd : mrd - cval;
        ST_DMUL: prod <= a * a;
        ST_DACC: begin
          sq <= sq_next;
          if (ch != 2'd2) ch <= ch + 2'd1;
        end
        ST_DSQ: begin
          if (sqrt_done) begin
            dsum[qk] <= dsum[qk] + DSW'(sq_root);
            ch   <= '0;
            sq   <= '0;
            kidx <= kidx + 5'd1;
            cx   <= cx_n;
            cy   <= cy_n;
          end
          qi   <= '0;
          best <= BEST_INIT;
          bsel <= 1'b0;
          bq   <= '0;
        end
        ST_VWAIT: begin
          if (div_done) begin
            if ({1'b0, dev} < best) begin
              best <= {1'b0, dev};
              bq   <= qi;
              bsel <= 1'b1;
            end
            qi <= qi + 2'd1;
          end
          ch <= '0;
        end
        ST_PICK: begin
          if (!bsel)          res[ch] <= chan_of(win[12], ch);
          else if (rnd[MW])   res[ch] <= 8'hFF;
          else                res[ch] <= rnd[MW-1:FRAC];
          ch <= ch + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {res[2], res[1], res[0]};
      m_tlast  <= fe;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_rd_pipe_in_rd: assert property (@(posedge clk) disable iff (rst)
    rv |-> state == ST_RD)
    else $error("window read pipeline active outside read phase");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && m_tvalid && !m_tready) |=> state == ST_EMIT && m_tvalid)
    else $error("pending result overwritten");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_done && !sqrt_done)
    else $error("arithmetic unit finished while idle");

  a_load_after_pick: assert property (@(posedge clk) disable iff (rst)
    out_load |-> $past(state) == ST_PICK || $past(state) == ST_EMIT)
    else $error("result loaded without selection");
`endif

endmodule
